>>> hw/rtl/gcm_pkg.sv
`timescale 1ns / 1ps

package gcm_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int MAX_STOPS_DEF  = 4;

	localparam int IN_BITS     = 16;
	localparam int COLOR_BITS  = 24;
	localparam int CFG_BITS    = 48;
	localparam int ADDR_BITS   = 4;
	localparam int STOP_BITS   = 40;
	localparam int SPOS_BITS   = 16;
	localparam int SPOS_LSB    = 24;
	localparam int COUNT_BITS  = 3;
	localparam int STATUS_BITS = 2;

	// q1.16 position, 0..65536
	localparam int POS_BITS = 17;
	localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1 << 16);

	localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOCOVER = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_INVALID = 2'd2;

	localparam logic [ADDR_BITS-1:0] REG_RANGE_MIN = 4'd0;
	localparam logic [ADDR_BITS-1:0] REG_RANGE_MAX = 4'd1;
	localparam logic [ADDR_BITS-1:0] REG_OUTSIDE   = 4'd2;
	localparam logic [ADDR_BITS-1:0] REG_COUNT     = 4'd3;
	localparam logic [ADDR_BITS-1:0] REG_STOP0     = 4'd4;

endpackage

>>> hw/rtl/gcm_div.sv
`timescale 1ns / 1ps

// restoring divider of (num << 16) by den, num <= den, one quotient bit per stage
module gcm_div #(
	parameter int DW = 16,
	parameter int PW = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [DW-1:0]                 num,
	input  logic [DW-1:0]                 den,
	input  logic [PW-1:0]                 in_pay,
	output logic                          out_valid,
	output logic [gcm_pkg::POS_BITS-1:0]  quo,
	output logic [PW-1:0]                 out_pay
);

	localparam int STEPS = gcm_pkg::POS_BITS;

	logic             vld_s [STEPS];
	logic [DW-1:0]    rem_s [STEPS];
	logic [DW-1:0]    den_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];
	logic [PW-1:0]    pay_s [STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (num >= den) begin
			rem_s[0] <= num - den;
			quo_s[0] <= STEPS'(1);
		end else begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
		end
		den_s[0] <= den;
		pay_s[0] <= in_pay;
	end

	for (genvar k = 1; k < STEPS; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;

		assign t    = {rem_s[k-1], 1'b0};
		assign diff = t - {1'b0, den_s[k-1]};
		assign ge   = (t >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
			quo_s[k] <= {quo_s[k-1][STEPS-2:0], ge};
			den_s[k] <= den_s[k-1];
			pay_s[k] <= pay_s[k-1];
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign quo       = quo_s[STEPS-1];
	assign out_pay   = pay_s[STEPS-1];

endmodule

>>> hw/rtl/gradient_color_map_unit.sv
`timescale 1ns / 1ps

// the strobe follows start via stage 1, position divider, stage 2, weight divider, output register
// throughput: one value per cycle, busy stays low; the receiver cannot stall
// two 17-stage restoring dividers (position, then segment weight) set the depth
// reset: asynchronous active low, clears registers to their reset values and
// empties the pipeline
module gradient_color_map_unit #(
	parameter int VALUE_BITS = gcm_pkg::VALUE_BITS_DEF,
	parameter int MAX_STOPS  = gcm_pkg::MAX_STOPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [gcm_pkg::IN_BITS-1:0]       value,
	output logic                              strobe,
	output logic [gcm_pkg::COLOR_BITS-1:0]    color,
	output logic [gcm_pkg::STATUS_BITS-1:0]   status,
	input  logic                              cfg_we,
	input  logic [gcm_pkg::ADDR_BITS-1:0]     cfg_addr,
	input  logic [gcm_pkg::CFG_BITS-1:0]      cfg_wdata
);

	localparam int WB  = (VALUE_BITS > 16) ? VALUE_BITS : 16;
	localparam int SW  = $clog2(MAX_STOPS);
	localparam int CB  = gcm_pkg::COLOR_BITS;
	localparam int PB  = gcm_pkg::POS_BITS;
	localparam int SB  = gcm_pkg::STATUS_BITS;
	localparam int P1W = SB + 1 + CB;
	localparam int P2W = P1W + 2 * CB;
	localparam logic [WB-1:0] TOP = WB'((64'd1 << VALUE_BITS) - 64'd1);

	// configuration
	logic [15:0]                        range_min_q;
	logic [15:0]                        range_max_q;
	logic [2*CB-1:0]                    outside_q;
	logic [gcm_pkg::COUNT_BITS-1:0]     count_q;
	logic [gcm_pkg::STOP_BITS-1:0]      stop_q [MAX_STOPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			range_max_q <= 16'hFFFF;
			outside_q   <= '0;
			count_q     <= '0;
			for (int k = 0; k < MAX_STOPS; k++) begin
				stop_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_addr == gcm_pkg::REG_RANGE_MIN) begin
				range_min_q <= cfg_wdata[15:0];
			end
			if (cfg_addr == gcm_pkg::REG_RANGE_MAX) begin
				range_max_q <= cfg_wdata[15:0];
			end
			if (cfg_addr == gcm_pkg::REG_OUTSIDE) begin
				outside_q <= cfg_wdata[2*CB-1:0];
			end
			if (cfg_addr == gcm_pkg::REG_COUNT) begin
				count_q <= cfg_wdata[gcm_pkg::COUNT_BITS-1:0];
			end
			for (int k = 0; k < MAX_STOPS; k++) begin
				if (cfg_addr == gcm_pkg::ADDR_BITS'(gcm_pkg::REG_STOP0 + k)) begin
					stop_q[k] <= cfg_wdata[gcm_pkg::STOP_BITS-1:0];
				end
			end
		end
	end

	assign busy = 1'b0;

	// stage 1: range checks and divider operands
	logic [WB-1:0] v_c, lo_c, hi_c, max_ext;
	logic [P1W-1:0] pay1_c;

	assign max_ext = WB'(range_max_q);
	assign lo_c    = WB'(range_min_q);
	assign hi_c    = (max_ext > TOP) ? TOP : max_ext;
	assign v_c     = WB'(value) & TOP;

	always_comb begin
		pay1_c = {gcm_pkg::ST_OK, 1'b0, {CB{1'b0}}};
		priority if (lo_c >= hi_c) begin
			pay1_c = {gcm_pkg::ST_INVALID, 1'b1, {CB{1'b0}}};
		end else if (v_c < lo_c) begin
			pay1_c = {gcm_pkg::ST_OK, 1'b1, outside_q[2*CB-1:CB]};
		end else if (v_c > hi_c) begin
			pay1_c = {gcm_pkg::ST_OK, 1'b1, outside_q[CB-1:0]};
		end else begin
			pay1_c = {gcm_pkg::ST_OK, 1'b0, {CB{1'b0}}};
		end
	end

	logic           vld_s1;
	logic [WB-1:0]  num_s1, den_s1;
	logic [P1W-1:0] pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= v_c - lo_c;
		den_s1 <= hi_c - lo_c;
		pay_s1 <= pay1_c;
	end

	logic           d1_vld;
	logic [PB-1:0]  pos;
	logic [P1W-1:0] d1_pay;

	gcm_div #(.DW(WB), .PW(P1W)) u_pos_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s1),
		.num      (num_s1),
		.den      (den_s1),
		.in_pay   (pay_s1),
		.out_valid(d1_vld),
		.quo      (pos),
		.out_pay  (d1_pay)
	);

	// segment search, last match wins
	logic [gcm_pkg::COUNT_BITS-1:0] n_c;
	logic                           hit_c;
	logic [SW-1:0]                  sel_c, sel2_c;
	logic [PB-1:0]                  p1_c, p2_c;
	logic [CB-1:0]                  c1_c, c2_c;

	assign n_c = (count_q > gcm_pkg::COUNT_BITS'(MAX_STOPS))
		? gcm_pkg::COUNT_BITS'(MAX_STOPS) : count_q;

	always_comb begin
		logic [PB-1:0] a, b;
		hit_c = 1'b0;
		sel_c = '0;
		for (int i = 0; i < MAX_STOPS - 1; i++) begin
			a = PB'(stop_q[i][gcm_pkg::SPOS_LSB +: gcm_pkg::SPOS_BITS]);
			b = PB'(stop_q[i+1][gcm_pkg::SPOS_LSB +: gcm_pkg::SPOS_BITS]);
			if ((i + 1 < int'(n_c)) && pos >= a && pos <= b) begin
				hit_c = 1'b1;
				sel_c = SW'(i);
			end
		end
	end

	assign sel2_c = sel_c + SW'(1);
	assign p1_c   = PB'(stop_q[sel_c][gcm_pkg::SPOS_LSB +: gcm_pkg::SPOS_BITS]);
	assign p2_c   = PB'(stop_q[sel2_c][gcm_pkg::SPOS_LSB +: gcm_pkg::SPOS_BITS]);
	assign c1_c   = stop_q[sel_c][CB-1:0];
	assign c2_c   = stop_q[sel2_c][CB-1:0];

	logic [SB-1:0] st1;
	logic          fix1;
	logic [CB-1:0] col1;
	assign {st1, fix1, col1} = d1_pay;

	logic           vld_s2;
	logic [PB-1:0]  num_s2, den_s2;
	logic [P2W-1:0] pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		num_s2 <= pos - p1_c;
		den_s2 <= p2_c - p1_c;
		priority if (fix1) begin
			pay_s2 <= {st1, 1'b1, col1, c1_c, c2_c};
		end else if (!hit_c) begin
			pay_s2 <= {gcm_pkg::ST_NOCOVER, 1'b1, {CB{1'b0}}, c1_c, c2_c};
		end else if (p1_c == p2_c) begin
			// zero-width segment takes the later stop
			pay_s2 <= {gcm_pkg::ST_OK, 1'b1, c2_c, c1_c, c2_c};
		end else begin
			pay_s2 <= {gcm_pkg::ST_OK, 1'b0, {CB{1'b0}}, c1_c, c2_c};
		end
	end

	logic           d2_vld;
	logic [PB-1:0]  w;
	logic [P2W-1:0] d2_pay;

	gcm_div #(.DW(PB), .PW(P2W)) u_wgt_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s2),
		.num      (num_s2),
		.den      (den_s2),
		.in_pay   (pay_s2),
		.out_valid(d2_vld),
		.quo      (w),
		.out_pay  (d2_pay)
	);

	// blend and output register
	logic [SB-1:0] st2;
	logic          fix2;
	logic [CB-1:0] col2, ca, cb, mix_c;
	logic [PB-1:0] wi;

	assign {st2, fix2, col2, ca, cb} = d2_pay;
	assign wi = gcm_pkg::POS_ONE - w;

	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		logic [PB+8:0] sum;
		assign sum = (PB+9)'(ca[8*ch +: 8]) * (PB+9)'(wi)
			+ (PB+9)'(cb[8*ch +: 8]) * (PB+9)'(w);
		assign mix_c[8*ch +: 8] = sum[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		color  <= fix2 ? col2 : mix_c;
		status <= st2;
	end

endmodule

>>> verif/gradient_color_map_unit_tb.sv
`timescale 1ns / 1ps

module gradient_color_map_unit_tb;

	localparam int LATENCY = 37;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            start = 1'b0;
	logic                            busy;
	logic [gcm_pkg::IN_BITS-1:0]     value = '0;
	logic                            strobe;
	logic [gcm_pkg::COLOR_BITS-1:0]  color;
	logic [gcm_pkg::STATUS_BITS-1:0] status;
	logic                            cfg_we = 1'b0;
	logic [gcm_pkg::ADDR_BITS-1:0]   cfg_addr = '0;
	logic [gcm_pkg::CFG_BITS-1:0]    cfg_wdata = '0;

	typedef struct packed {
		logic [gcm_pkg::COLOR_BITS-1:0]  color;
		logic [gcm_pkg::STATUS_BITS-1:0] status;
	} pixel_t;

	// shadow of the color map registers
	logic [15:0]                   lo_reg;
	logic [15:0]                   hi_reg;
	logic [47:0]                   outside_reg;
	logic [2:0]                    count_reg;
	logic [gcm_pkg::STOP_BITS-1:0] stop_reg [4];

	pixel_t pixel_q [$];
	int     n_err = 0;
	int     n_checked = 0;
	int     n_sent = 0;
	int     n_cfg = 0;
	bit     timed_out = 0;

	gradient_color_map_unit dut (.*);

	always #2 clk = ~clk;

	function automatic logic [16:0] stop_position(int k);
		logic [16:0] p;
		p = {1'b0, stop_reg[k][gcm_pkg::SPOS_LSB +: gcm_pkg::SPOS_BITS]};
		return p;
	endfunction

	function automatic logic [23:0] mix_colors(logic [23:0] c1, logic [23:0] c2,
		logic [16:0] w);
		logic [23:0] r;
		logic [40:0] ch;
		r = '0;
		for (int s = 0; s < 3; s++) begin
			ch = c1[s*8 +: 8] * (41'(gcm_pkg::POS_ONE) - w) + c2[s*8 +: 8] * 41'(w);
			r[s*8 +: 8] = ch[23:16];
		end
		return r;
	endfunction

	function automatic pixel_t map_pixel(logic [15:0] v);
		pixel_t      px;
		logic [32:0] pos;
		logic [32:0] w;
		logic [16:0] p1, p2;
		int          n;
		bit          hit;
		px = '0;
		if (lo_reg >= hi_reg) begin
			px.status = gcm_pkg::ST_INVALID;
		end else if (v < lo_reg) begin
			px.color = outside_reg[47:24];
		end else if (v > hi_reg) begin
			px.color = outside_reg[23:0];
		end else begin
			pos = ({17'd0, v - lo_reg} << 16) / (hi_reg - lo_reg);
			n = (count_reg > 4) ? 4 : count_reg;
			hit = 0;
			for (int i = 0; i + 1 < n; i++) begin
				p1 = stop_position(i);
				p2 = stop_position(i + 1);
				if (pos >= p1 && pos <= p2) begin
					hit = 1;
					if (p1 == p2) begin
						px.color = stop_reg[i + 1][23:0];
					end else begin
						w = ((pos - p1) << 16) / (p2 - p1);
						px.color = mix_colors(stop_reg[i][23:0],
							stop_reg[i + 1][23:0], w[16:0]);
					end
				end
			end
			if (!hit) begin
				px.color = '0;
				px.status = gcm_pkg::ST_NOCOVER;
			end
		end
		return px;
	endfunction

	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && strobe) begin
			if (pixel_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected beat color=%h status=%0d", color, status);
			end else begin
				exp_px = pixel_q.pop_front();
				n_checked++;
				if (color !== exp_px.color || status !== exp_px.status) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: exp color=%h status=%0d got color=%h status=%0d",
							exp_px.color, exp_px.status, color, status);
				end
			end
		end
	end

	task automatic write_reg(logic [gcm_pkg::ADDR_BITS-1:0] a,
		logic [gcm_pkg::CFG_BITS-1:0] d);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(posedge clk);
		case (a)
			gcm_pkg::REG_RANGE_MIN: lo_reg = d[15:0];
			gcm_pkg::REG_RANGE_MAX: hi_reg = d[15:0];
			gcm_pkg::REG_OUTSIDE:   outside_reg = d[47:0];
			gcm_pkg::REG_COUNT:     count_reg = d[2:0];
			default: if (a >= gcm_pkg::REG_STOP0 && a < gcm_pkg::REG_STOP0 + 4)
				stop_reg[a - gcm_pkg::REG_STOP0] = d[gcm_pkg::STOP_BITS-1:0];
		endcase
		n_cfg++;
	endtask

	// waits for the pipeline to drain before touching registers
	task automatic drain;
		start <= 1'b0;
		cfg_we <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic send_value(logic [15:0] v);
		cfg_we <= 1'b0;
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		pixel_q = {pixel_q, map_pixel(v)};
		n_sent++;
	endtask

	function automatic logic [39:0] make_stop(logic [15:0] p, logic [23:0] c);
		return {p, c};
	endfunction

	task automatic random_burst(int items, bit wide);
		int left;
		int len;
		left = items;
		while (left > 0) begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len && left > 0; i++) begin
				if (wide || $urandom_range(0, 3) == 0)
					send_value(16'($urandom));
				else
					send_value(16'($urandom_range(lo_reg, hi_reg)));
				left--;
			end
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic random_config;
		logic [15:0] p [4];
		int          m;
		if ($urandom_range(0, 5) == 0) begin
			write_reg(gcm_pkg::REG_RANGE_MIN, 48'($urandom));
			write_reg(gcm_pkg::REG_RANGE_MAX, 48'($urandom));
		end else begin
			m = $urandom_range(0, 65000);
			write_reg(gcm_pkg::REG_RANGE_MIN, 48'(m));
			write_reg(gcm_pkg::REG_RANGE_MAX, 48'($urandom_range(m + 1, 65535)));
		end
		write_reg(gcm_pkg::REG_OUTSIDE, {16'($urandom), 32'($urandom)});
		write_reg(gcm_pkg::REG_COUNT, 48'($urandom_range(0, 7)));
		for (int k = 0; k < 4; k++) p[k] = 16'($urandom);
		if ($urandom_range(0, 1)) p.sort();
		if ($urandom_range(0, 3) == 0) p[2] = p[1];
		for (int k = 0; k < 4; k++)
			write_reg(gcm_pkg::REG_STOP0 + k,
				{8'($urandom), make_stop(p[k], 24'($urandom))});
	endtask

	task automatic test_reset_defaults;
		send_value(16'd0);
		send_value(16'hFFFF);
		drain();
	endtask

	task automatic test_directed;
		write_reg(gcm_pkg::REG_RANGE_MIN, 48'd0);
		write_reg(gcm_pkg::REG_RANGE_MAX, 48'hFFFF);
		write_reg(gcm_pkg::REG_OUTSIDE, 48'hFFFFFF_000000);
		write_reg(gcm_pkg::REG_COUNT, 48'd4);
		write_reg(gcm_pkg::REG_STOP0,     make_stop(16'h0000, 24'hFF0000));
		write_reg(gcm_pkg::REG_STOP0 + 1, make_stop(16'h4000, 24'h00FF00));
		write_reg(gcm_pkg::REG_STOP0 + 2, make_stop(16'h4000, 24'h0000FF));
		write_reg(gcm_pkg::REG_STOP0 + 3, make_stop(16'hFFFF, 24'hFFFFFF));
		write_reg(4'd9, 48'hFFFF_FFFF_FFFF);
		n_cfg--;
		for (int i = 0; i < 16; i++) send_value(16'(1 << i));
		send_value(16'h0000);
		send_value(16'hFFFF);
		send_value(16'h3FFF);
		drain();
		// narrow window: below, above, invalid and too many stops
		write_reg(gcm_pkg::REG_RANGE_MIN, 48'd100);
		write_reg(gcm_pkg::REG_RANGE_MAX, 48'd200);
		write_reg(gcm_pkg::REG_COUNT, 48'd7);
		send_value(16'd99);
		send_value(16'd100);
		send_value(16'd150);
		send_value(16'd200);
		send_value(16'd201);
		drain();
		write_reg(gcm_pkg::REG_RANGE_MAX, 48'd100);
		send_value(16'd100);
		drain();
		write_reg(gcm_pkg::REG_COUNT, 48'd1);
		write_reg(gcm_pkg::REG_RANGE_MAX, 48'd300);
		send_value(16'd150);
		drain();
	endtask

	task automatic test_random;
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			random_burst(100, ph[0]);
			drain();
		end
	endtask

	initial begin
		lo_reg = 16'd0;
		hi_reg = 16'hFFFF;
		outside_reg = '0;
		count_reg = '0;
		foreach (stop_reg[k]) stop_reg[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random();
		$display("sent %0d values over %0d register writes, %0d results checked",
			n_sent, n_cfg, n_checked);
		if (n_err == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", pixel_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
